/* rtl/btag_pkg.sv */
// Shared types and constants for the bilinear texel address generator.
// Used by btag_axis, btag_index and bilinear_texel_address_gen_unit; no dependencies.
package btag_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 20;
  localparam int CLAMP_W   = FRAC_BITS + 1;
  localparam int DIM_W     = 13;
  localparam int STRIDE_W  = 3;
  localparam int ROW_W     = DIM_W + STRIDE_W;
  localparam int PROD_W    = CLAMP_W + DIM_W;
  localparam int INDEX_W   = 26;
  localparam int WEIGHT_W  = FRAC_BITS + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0]     MAX_DIM = 13'd4096;
  localparam logic [CLAMP_W-1:0]   ONE     = CLAMP_W'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] HALF    = FRAC_BITS'(1) << (FRAC_BITS - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STRIDE = 2'd2;

  localparam logic [DIM_W-1:0]    RESET_WIDTH  = 13'd256;
  localparam logic [DIM_W-1:0]    RESET_HEIGHT = 13'd256;
  localparam logic [STRIDE_W-1:0] RESET_STRIDE = 3'd4;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_LOW  = 2'd1,
    DIR_HIGH = 2'd2
  } dir_t;

  typedef struct packed {
    logic [DIM_W-1:0]    pixel;
    dir_t                dir;
    logic [WEIGHT_W-1:0] weight;
  } axis_res_t;

  typedef struct packed {
    logic clamp;
    logic prod;
    logic res;
  } axis_adv_t;

  typedef struct packed {
    logic main;
    logic out;
  } index_adv_t;

endpackage

/* rtl/bilinear_texel_address_gen_unit.sv */
// Top level of the bilinear texel address generator: configuration registers,
// pipeline valid/ready control and assertions. Depends on btag_pkg, btag_axis, btag_index.
//
// Usage:
//   Input channel (in_valid/in_ready, coord_s, coord_t) takes one signed Q.16
//   coordinate pair per item. Output channel (out_valid/out_ready) returns the
//   main, s, t and diagonal neighbor element indexes and the per-axis weights.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   image_width (0), image_height (1) and pixel_stride (2); cfg_ready is always
//   high and other indexes are dropped. Write configuration only while no items
//   are in flight.
// Timing:
//   Five register stages: clamp, scale multiply, axis resolve, row/column
//   multiply-add, neighbor adders. One item per cycle is sustained while
//   out_ready stays high.
// Reset (rst, synchronous): empties the pipeline and loads width 256,
//   height 256, stride 4.
// Stall: when out_ready is low a full stage holds only if the one after it holds;
//   empty stages still advance, so in_ready drops only once all five are full.
module bilinear_texel_address_gen_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [btag_pkg::COORD_W-1:0] coord_s,
  input  logic signed [btag_pkg::COORD_W-1:0] coord_t,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [btag_pkg::INDEX_W-1:0]        main_index,
  output logic [btag_pkg::INDEX_W-1:0]        s_neighbor_index,
  output logic [btag_pkg::INDEX_W-1:0]        t_neighbor_index,
  output logic [btag_pkg::INDEX_W-1:0]        diag_neighbor_index,
  output logic [btag_pkg::WEIGHT_W-1:0]       weight_s,
  output logic [btag_pkg::WEIGHT_W-1:0]       weight_t,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [btag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [btag_pkg::DIM_W-1:0]          cfg_data
);
  import btag_pkg::*;

  localparam int NSTAGE = 5;

  logic [DIM_W-1:0]    image_width;
  logic [DIM_W-1:0]    image_height;
  logic [STRIDE_W-1:0] pixel_stride;
  logic [DIM_W-1:0]    width_sat;
  logic [DIM_W-1:0]    height_sat;
  logic [ROW_W-1:0]    row;

  logic [NSTAGE-1:0]   stage_valid;
  logic [NSTAGE-1:0]   stage_ready;

  axis_adv_t           axis_adv;
  index_adv_t          index_adv;
  axis_res_t           res_s;
  axis_res_t           res_t;

  assign cfg_ready = 1'b1;

  // Configuration registers, written whole; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      pixel_stride <= RESET_STRIDE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_PIXEL_STRIDE: pixel_stride <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero dimension acts as one; anything above the maximum saturates.
  always_comb begin
    if (image_width == '0)         width_sat = DIM_W'(1);
    else if (image_width > MAX_DIM) width_sat = MAX_DIM;
    else                            width_sat = image_width;
    if (image_height == '0)         height_sat = DIM_W'(1);
    else if (image_height > MAX_DIM) height_sat = MAX_DIM;
    else                             height_sat = image_height;
  end

  // Row pitch in elements; settles well before any item reaches the index stage.
  always_ff @(posedge clk) begin
    row <= ROW_W'(pixel_stride) * ROW_W'(width_sat);
  end

  // Ready ripples back from the output: a stage may load when it is empty
  // or when the stage after it is loading too.
  always_comb begin
    stage_ready[NSTAGE-1] = !stage_valid[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  assign in_ready  = stage_ready[0];
  assign out_valid = stage_valid[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) stage_valid[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (stage_ready[k]) stage_valid[k] <= stage_valid[k-1];
      end
    end
  end

  always_comb begin
    axis_adv.clamp = stage_ready[0];
    axis_adv.prod  = stage_ready[1];
    axis_adv.res   = stage_ready[2];
    index_adv.main = stage_ready[3];
    index_adv.out  = stage_ready[4];
  end

  btag_axis u_axis_s (
    .clk   (clk),
    .adv   (axis_adv),
    .coord (coord_s),
    .dim   (width_sat),
    .res   (res_s)
  );

  btag_axis u_axis_t (
    .clk   (clk),
    .adv   (axis_adv),
    .coord (coord_t),
    .dim   (height_sat),
    .res   (res_t)
  );

  btag_index u_index (
    .clk                 (clk),
    .adv                 (index_adv),
    .res_s               (res_s),
    .res_t               (res_t),
    .stride              (pixel_stride),
    .row                 (row),
    .main_index          (main_index),
    .s_neighbor_index    (s_neighbor_index),
    .t_neighbor_index    (t_neighbor_index),
    .diag_neighbor_index (diag_neighbor_index),
    .weight_s            (weight_s),
    .weight_t            (weight_t)
  );

  // Input backs up only when the whole pipeline is full and the output stalls.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (stage_valid == '1) && !out_ready)
    else $error("input stalled while pipeline has room");

  // Weights stay between one half and one.
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weight_s >= 17'd32768) && (weight_s <= 17'd65536)
               && (weight_t >= 17'd32768) && (weight_t <= 17'd65536))
    else $error("weight out of range");

  // Diagonal offset is the sum of the s and t offsets.
  a_diag_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> INDEX_W'(diag_neighbor_index + main_index)
               == INDEX_W'(s_neighbor_index + t_neighbor_index))
    else $error("diagonal neighbor inconsistent with s and t neighbors");

  // An item entering shows up in the first stage on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> stage_valid[0])
    else $error("accepted item lost at pipeline entry");

endmodule

/* rtl/btag_axis.sv */
// One coordinate axis: clamp, scale by dimension, resolve pixel, neighbor side and weight.
// Three register stages; depends on btag_pkg.
module btag_axis (
  input  logic                            clk,
  input  btag_pkg::axis_adv_t             adv,
  input  logic signed [btag_pkg::COORD_W-1:0] coord,
  input  logic [btag_pkg::DIM_W-1:0]      dim,
  output btag_pkg::axis_res_t             res
);
  import btag_pkg::*;

  localparam int Q_W = PROD_W - FRAC_BITS;

  logic [CLAMP_W-1:0]   clamped;
  logic [CLAMP_W-1:0]   clamped_next;
  logic [PROD_W-1:0]    prod;
  logic [Q_W-1:0]       q;
  logic [FRAC_BITS-1:0] f;
  logic [FRAC_BITS-1:0] center_dist;
  axis_res_t            res_next;

  always_comb begin
    if (coord[COORD_W-1]) begin
      clamped_next = '0;
    end else if (coord[COORD_W-2:0] > (COORD_W-1)'(ONE)) begin
      clamped_next = ONE;
    end else begin
      clamped_next = coord[CLAMP_W-1:0];
    end
  end

  always_comb begin
    q    = prod[PROD_W-1:FRAC_BITS];
    f    = prod[FRAC_BITS-1:0];
    center_dist = (f >= HALF) ? (f - HALF) : (HALF - f);
    res_next.weight = ONE - {1'b0, center_dist};
    if (q >= Q_W'(dim)) begin
      res_next.pixel = dim - DIM_W'(1);
    end else begin
      res_next.pixel = q[DIM_W-1:0];
    end
    if (res_next.pixel != '0 && f < HALF) begin
      res_next.dir = DIR_LOW;
    end else if ((Q_W'(res_next.pixel) + Q_W'(1)) < Q_W'(dim) && f > HALF) begin
      res_next.dir = DIR_HIGH;
    end else begin
      res_next.dir = DIR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.clamp) clamped <= clamped_next;
    if (adv.prod)  prod    <= PROD_W'(clamped) * PROD_W'(dim);
    if (adv.res)   res     <= res_next;
  end

endmodule

/* rtl/btag_index.sv */
// Element index stages: main texel index, then the three neighbor indexes.
// Two register stages; depends on btag_pkg.
module btag_index (
  input  logic                          clk,
  input  btag_pkg::index_adv_t          adv,
  input  btag_pkg::axis_res_t           res_s,
  input  btag_pkg::axis_res_t           res_t,
  input  logic [btag_pkg::STRIDE_W-1:0] stride,
  input  logic [btag_pkg::ROW_W-1:0]    row,
  output logic [btag_pkg::INDEX_W-1:0]  main_index,
  output logic [btag_pkg::INDEX_W-1:0]  s_neighbor_index,
  output logic [btag_pkg::INDEX_W-1:0]  t_neighbor_index,
  output logic [btag_pkg::INDEX_W-1:0]  diag_neighbor_index,
  output logic [btag_pkg::WEIGHT_W-1:0] weight_s,
  output logic [btag_pkg::WEIGHT_W-1:0] weight_t
);
  import btag_pkg::*;

  localparam int ROWOFF_W = DIM_W + ROW_W;

  logic [ROWOFF_W-1:0] row_off;
  logic [ROW_W-1:0]    col_off;
  logic [INDEX_W-1:0]  main_q;
  dir_t                dir_s;
  dir_t                dir_t_q;
  logic [WEIGHT_W-1:0] w_s;
  logic [WEIGHT_W-1:0] w_t;
  logic [INDEX_W-1:0]  s_off;
  logic [INDEX_W-1:0]  t_off;

  always_comb begin
    row_off = ROWOFF_W'(res_t.pixel) * ROWOFF_W'(row);
    col_off = ROW_W'(res_s.pixel) * ROW_W'(stride);
  end

  always_comb begin
    case (dir_s)
      DIR_LOW:  s_off = -INDEX_W'(stride);
      DIR_HIGH: s_off = INDEX_W'(stride);
      default:  s_off = '0;
    endcase
    case (dir_t_q)
      DIR_LOW:  t_off = -INDEX_W'(row);
      DIR_HIGH: t_off = INDEX_W'(row);
      default:  t_off = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.main) begin
      main_q  <= INDEX_W'(row_off + ROWOFF_W'(col_off));
      dir_s   <= res_s.dir;
      dir_t_q <= res_t.dir;
      w_s     <= res_s.weight;
      w_t     <= res_t.weight;
    end
    if (adv.out) begin
      main_index          <= main_q;
      s_neighbor_index    <= main_q + s_off;
      t_neighbor_index    <= main_q + t_off;
      diag_neighbor_index <= main_q + t_off + s_off;
      weight_s            <= w_s;
      weight_t            <= w_t;
    end
  end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for bilinear_texel_address_gen_unit: streams texture
// coordinate pairs, predicts texel indexes and weights in-line, and checks every result.
// Depends on btag_pkg and the RTL of the block; nothing else.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import btag_pkg::*;

  // Pipeline depth, used with a margin for the settle time after a drain
  localparam int PIPE_LATENCY = 5;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;
  // Index past the end of the register list; the block must drop it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [COORD_W-1:0] COORD_ZERO = '0;
  localparam logic [COORD_W-1:0] COORD_ONE  = COORD_W'(ONE);
  localparam logic [COORD_W-1:0] COORD_HALF = COORD_W'(HALF);

  // One result item: four element indexes and two main-texel weights
  typedef struct packed {
    logic [INDEX_W-1:0]  main_idx;
    logic [INDEX_W-1:0]  s_idx;
    logic [INDEX_W-1:0]  t_idx;
    logic [INDEX_W-1:0]  diag_idx;
    logic [WEIGHT_W-1:0] w_s;
    logic [WEIGHT_W-1:0] w_t;
  } texel_set_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [COORD_W-1:0]    coord_s   = '0;
  logic [COORD_W-1:0]    coord_t   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [INDEX_W-1:0]    main_index;
  logic [INDEX_W-1:0]    s_neighbor_index;
  logic [INDEX_W-1:0]    t_neighbor_index;
  logic [INDEX_W-1:0]    diag_neighbor_index;
  logic [WEIGHT_W-1:0]   weight_s;
  logic [WEIGHT_W-1:0]   weight_t;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [DIM_W-1:0]      cfg_data  = '0;

  // Shadow copy of the configuration registers, as the block should hold them
  logic [DIM_W-1:0]      model_width  = RESET_WIDTH;
  logic [DIM_W-1:0]      model_height = RESET_HEIGHT;
  logic [STRIDE_W-1:0]   model_stride = RESET_STRIDE;

  // Expected results, oldest first
  texel_set_t            pending_texels[$];
  int                    mismatches  = 0;
  int                    cycle_count = 0;

  // Per-cycle idle chances in percent for the two sides
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;

  // Long receiver hold-off, timed by its own process
  event                  stall_start;
  int                    stall_cycles = 0;
  logic                  recv_hold    = 1'b0;

  bilinear_texel_address_gen_unit i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .coord_s             (coord_s),
    .coord_t             (coord_t),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .main_index          (main_index),
    .s_neighbor_index    (s_neighbor_index),
    .t_neighbor_index    (t_neighbor_index),
    .diag_neighbor_index (diag_neighbor_index),
    .weight_s            (weight_s),
    .weight_t            (weight_t),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Zero means one pixel, anything past MAX_DIM is capped at MAX_DIM
  function automatic logic [DIM_W-1:0] clip_dim(logic [DIM_W-1:0] raw_dim);
    if (raw_dim == '0) return DIM_W'(1);
    if (raw_dim > MAX_DIM) return MAX_DIM;
    return raw_dim;
  endfunction

  // Clamp one coordinate to [0, 1], scale by the dimension, then pick the
  // pixel, the neighbor side and the main-texel weight for that axis.
  function automatic axis_res_t resolve_axis(logic [COORD_W-1:0] raw, logic [DIM_W-1:0] dim);
    logic [CLAMP_W-1:0]          clamped;
    logic [PROD_W-1:0]           scaled;
    logic [PROD_W-FRAC_BITS-1:0] whole;
    logic [FRAC_BITS-1:0]        frac;
    logic [FRAC_BITS-1:0]        center_dist;
    axis_res_t                   res;
    if (raw[COORD_W-1]) begin
      clamped = '0;
    end else if (raw > COORD_ONE) begin
      clamped = ONE;
    end else begin
      clamped = raw[CLAMP_W-1:0];
    end
    scaled = clamped * dim;
    whole  = scaled[PROD_W-1:FRAC_BITS];
    frac   = scaled[FRAC_BITS-1:0];
    center_dist = (frac >= HALF) ? frac - HALF : HALF - frac;
    res.weight = ONE - WEIGHT_W'(center_dist);
    // The far edge lands one past the last pixel; pull it back
    res.pixel  = (whole >= dim) ? dim - 1'b1 : whole[DIM_W-1:0];
    if (res.pixel >= 1 && frac < HALF) begin
      res.dir = DIR_LOW;
    end else if (res.pixel + 1'b1 < dim && frac > HALF) begin
      res.dir = DIR_HIGH;
    end else begin
      res.dir = DIR_NONE;
    end
    return res;
  endfunction

  // Indexes are worked out wide and cut to 26 bits, so out-of-range
  // registers wrap just as the block's adders do.
  function automatic texel_set_t predict_texels(logic [COORD_W-1:0] s, logic [COORD_W-1:0] t);
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    axis_res_t        ax_s;
    axis_res_t        ax_t;
    longint unsigned  st;
    longint unsigned  row;
    longint unsigned  base;
    longint unsigned  s_off;
    longint unsigned  t_off;
    longint unsigned  diag;
    texel_set_t       res;
    w     = clip_dim(model_width);
    h     = clip_dim(model_height);
    st    = model_stride;
    row   = st * w;
    ax_s  = resolve_axis(s, w);
    ax_t  = resolve_axis(t, h);
    base  = ax_t.pixel * row + ax_s.pixel * st;
    s_off = 0;
    t_off = 0;
    case (ax_s.dir)
      DIR_LOW:  s_off = -st;
      DIR_HIGH: s_off = st;
      default:  s_off = 0;
    endcase
    case (ax_t.dir)
      DIR_LOW:  t_off = -row;
      DIR_HIGH: t_off = row;
      default:  t_off = 0;
    endcase
    diag = base + t_off + s_off;
    res.main_idx = INDEX_W'(base);
    res.s_idx    = INDEX_W'(base + s_off);
    res.t_idx    = INDEX_W'(base + t_off);
    res.diag_idx = INDEX_W'(diag);
    res.w_s      = ax_s.weight;
    res.w_t      = ax_t.weight;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Drop ready at random, and hold it low for the whole of a requested stall
  always @(negedge clk) begin
    out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Count the long hold-off on the clock; the receiver only reads the flag
  always begin
    @(stall_start);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (stall_cycles) @(posedge clk);
    recv_hold <= 1'b0;
  end

  task automatic flag_mismatch(string why, texel_set_t want, texel_set_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("[%0t] %s: expected main %0d s %0d t %0d diag %0d ws %0d wt %0d",
               $realtime, why, want.main_idx, want.s_idx, want.t_idx, want.diag_idx,
               want.w_s, want.w_t);
      $display("          got      main %0d s %0d t %0d diag %0d ws %0d wt %0d",
               got.main_idx, got.s_idx, got.t_idx, got.diag_idx, got.w_s, got.w_t);
    end
  endtask

  // Compare every accepted result against the oldest expectation
  always @(posedge clk) begin
    texel_set_t got;
    texel_set_t want;
    if (!rst && out_valid && out_ready) begin
      got = {main_index, s_neighbor_index, t_neighbor_index, diag_neighbor_index,
             weight_s, weight_t};
      if (pending_texels.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, got);
      end else begin
        want = pending_texels.pop_front();
        if (got !== want) flag_mismatch("wrong result", want, got);
      end
    end
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one coordinate pair; idle first at random, then hold valid until taken.
  task automatic send_coords(logic [COORD_W-1:0] s, logic [COORD_W-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    coord_s  <= s;
    coord_t  <= t;
    do @(posedge clk); while (!in_ready);
    pending_texels.push_back(predict_texels(s, t));
  endtask

  // Stop offering, wait for every pending result, then let the pipe settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMAGE_WIDTH:  model_width  = data;
      REG_IMAGE_HEIGHT: model_height = data;
      REG_PIXEL_STRIDE: model_stride = data[STRIDE_W-1:0];
      default: ;  // unused index, the block drops it
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                              logic [DIM_W-1:0] st);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_PIXEL_STRIDE, st);
  endtask

  // Random coordinate, biased toward clamping, pixel centers and pixel borders
  function automatic logic [COORD_W-1:0] pick_coord(logic [DIM_W-1:0] dim);
    int unsigned pix;
    pix = $urandom_range(dim - 1);
    case ($urandom_range(9))
      0:       return COORD_W'($urandom);
      1:       return {1'b1, (COORD_W-1)'($urandom)};
      2:       return COORD_W'($urandom_range(524287, 65537));
      3:       return $urandom_range(1) ? COORD_ONE : COORD_ZERO;
      4:       return COORD_W'(((pix << FRAC_BITS) + HALF) / dim);
      5:       return COORD_W'((pix << FRAC_BITS) / dim);
      default: return COORD_W'($urandom_range(ONE));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry 256 x 256, stride 4: clamping, far edge, centers, borders
  task automatic test_reset_defaults();
    send_coords(COORD_ZERO, COORD_ZERO);
    send_coords(COORD_ONE, COORD_ONE);                   // far edge on both axes
    send_coords('1, 20'h80000);                          // negative clamps to zero
    send_coords(20'h7FFFF, COORD_ONE + 1'b1);            // above one clamps to one
    send_coords(COORD_W'(128), COORD_W'(384));           // exact pixel centers
    send_coords(COORD_HALF, COORD_HALF);                 // pixel border, low side
    send_coords(COORD_HALF + 1'b1, COORD_ONE - 1'b1);
    send_coords(20'h0AAAA, 20'h05555);
    drain_results();
  endtask

  // Smallest and largest legal geometry
  task automatic test_edge_dims();
    set_geometry(13'd1, 13'd1, 13'd1);
    send_coords(COORD_ONE, COORD_ONE);                   // far edge, no pixel d-2
    send_coords(COORD_ZERO, COORD_ZERO);
    send_coords(COORD_HALF, COORD_HALF);
    send_coords(COORD_W'(16384), COORD_W'(49152));
    drain_results();
    set_geometry(MAX_DIM, MAX_DIM, 13'd4);
    send_coords(COORD_ONE, COORD_ONE);                   // largest legal index
    send_coords(COORD_W'(1), COORD_ONE - 1'b1);
    send_coords(COORD_ZERO, COORD_W'(16));
    drain_results();
  endtask

  // Register values past the legal range, and a write to an unused index
  task automatic test_register_extremes();
    set_geometry(13'd0, 13'd0, 13'd0);                   // zero dims act as one
    send_coords(COORD_ONE, COORD_ONE);
    send_coords(COORD_W'(30000), COORD_W'(40000));
    drain_results();
    set_geometry(13'h1FFF, 13'h1FFF, 13'h1FFF);          // capped dims, stride 7
    send_coords(COORD_ONE, COORD_ONE);
    send_coords(COORD_W'(40000), COORD_W'(20000));
    drain_results();
    write_reg(REG_UNUSED, DIM_W'($urandom));
    send_coords(COORD_ONE, COORD_HALF);
    drain_results();
  endtask

  // Three idling profiles, each through four kinds of geometry
  task automatic test_random_traffic();
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] st;
    for (int profile = 0; profile < 3; profile++) begin
      case (profile)
        0:       begin send_idle_pct = 18; recv_idle_pct = 60; end
        1:       begin send_idle_pct = 60; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int setting = 0; setting < 4; setting++) begin
        case (setting)
          0: begin                                       // anywhere in range
            w  = DIM_W'($urandom_range(4096, 1));
            h  = DIM_W'($urandom_range(4096, 1));
            st = DIM_W'($urandom_range(4, 1));
          end
          1: begin                                       // tiny images, many borders
            w  = DIM_W'($urandom_range(8, 1));
            h  = DIM_W'($urandom_range(8, 1));
            st = DIM_W'($urandom_range(4, 1));
          end
          2: begin                                       // whole register range
            w  = DIM_W'($urandom_range(8191));
            h  = DIM_W'($urandom_range(8191));
            st = DIM_W'($urandom);
          end
          default: begin                                 // extremes
            w  = $urandom_range(1) ? MAX_DIM : DIM_W'(1);
            h  = $urandom_range(1) ? MAX_DIM : DIM_W'(1);
            st = $urandom_range(1) ? DIM_W'(4) : DIM_W'(1);
          end
        endcase
        set_geometry(w, h, st);
        for (int n = 0; n < 100; n++) begin
          send_coords(pick_coord(clip_dim(model_width)), pick_coord(clip_dim(model_height)));
        end
        drain_results();
      end
    end
  endtask

  // Hold the receiver off while the sender keeps offering, so the pipe fills and
  // in_ready drops; pause the sender until all is back, then repeat with random receiver idling.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_geometry(DIM_W'($urandom_range(4096, 1)), DIM_W'($urandom_range(4096, 1)),
                 DIM_W'($urandom_range(4, 1)));
    stall_cycles = 200;
    -> stall_start;
    for (int n = 0; n < 60; n++) begin
      send_coords(pick_coord(clip_dim(model_width)), pick_coord(clip_dim(model_height)));
    end
    drain_results();
    recv_idle_pct = 30;
    for (int n = 0; n < 40; n++) begin
      send_coords(pick_coord(clip_dim(model_width)), pick_coord(clip_dim(model_height)));
    end
    drain_results();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_edge_dims();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    if (mismatches == 0 && pending_texels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
